// File: hw/rtl/lscm_pkg.sv
// Package for the linear stretch colour mapper: shared types, constants, ramps.
// No dependencies.
package lscm_pkg;

  localparam int unsigned ONE_Q16 = 65536;

  localparam logic [1:0] REG_LOWER   = 2'd0;
  localparam logic [1:0] REG_UPPER   = 2'd1;
  localparam logic [1:0] REG_PALETTE = 2'd2;
  localparam logic [1:0] REG_COLOUR  = 2'd3;

  localparam logic [1:0] PAL_GREY    = 2'd0;
  localparam logic [1:0] PAL_VIRIDIS = 2'd1;
  localparam logic [1:0] PAL_ENERGY  = 2'd2;
  localparam logic [1:0] PAL_JET     = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic scan;       // update extremes from held item
    logic load;       // capture input item
    logic setup;      // resolve limits, start divider
    logic div_step;   // one quotient bit
    logic finish;     // clamp and map to pixel
  } lscm_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_render;
    logic div_done;
  } lscm_stat_t;

  function automatic logic [23:0] ramp_colour(input logic [1:0] pal, input logic [3:0] idx);
    logic [23:0] c;
    c = 24'h0;
    case (pal)
      PAL_ENERGY: begin
        case (idx)
          4'd0: c = {8'd48, 8'd18, 8'd59};    4'd1: c = {8'd65, 8'd69, 8'd171};
          4'd2: c = {8'd74, 8'd117, 8'd240};  4'd3: c = {8'd70, 8'd160, 8'd253};
          4'd4: c = {8'd49, 8'd198, 8'd223};  4'd5: c = {8'd34, 8'd225, 8'd190};
          4'd6: c = {8'd48, 8'd243, 8'd140};  4'd7: c = {8'd96, 8'd253, 8'd89};
          4'd8: c = {8'd146, 8'd255, 8'd52};  4'd9: c = {8'd188, 8'd243, 8'd42};
          4'd10: c = {8'd222, 8'd220, 8'd49}; 4'd11: c = {8'd247, 8'd187, 8'd49};
          4'd12: c = {8'd254, 8'd145, 8'd38}; 4'd13: c = {8'd241, 8'd99, 8'd22};
          4'd14: c = {8'd216, 8'd60, 8'd9};   default: c = {8'd165, 8'd20, 8'd2};
        endcase
      end
      PAL_JET: begin
        case (idx)
          4'd0: c = {8'd0, 8'd0, 8'd143};     4'd1: c = {8'd0, 8'd0, 8'd207};
          4'd2: c = {8'd0, 8'd0, 8'd255};     4'd3: c = {8'd0, 8'd63, 8'd255};
          4'd4: c = {8'd0, 8'd127, 8'd255};   4'd5: c = {8'd0, 8'd191, 8'd255};
          4'd6: c = {8'd38, 8'd255, 8'd214};  4'd7: c = {8'd93, 8'd255, 8'd159};
          4'd8: c = {8'd159, 8'd255, 8'd93};  4'd9: c = {8'd214, 8'd255, 8'd38};
          4'd10: c = {8'd255, 8'd208, 8'd0};  4'd11: c = {8'd255, 8'd145, 8'd0};
          4'd12: c = {8'd255, 8'd81, 8'd0};   4'd13: c = {8'd255, 8'd18, 8'd0};
          4'd14: c = {8'd207, 8'd0, 8'd0};    default: c = {8'd143, 8'd0, 8'd0};
        endcase
      end
      default: begin
        case (idx)
          4'd0: c = {8'd68, 8'd1, 8'd84};     4'd1: c = {8'd72, 8'd26, 8'd108};
          4'd2: c = {8'd71, 8'd47, 8'd125};   4'd3: c = {8'd65, 8'd68, 8'd135};
          4'd4: c = {8'd57, 8'd86, 8'd140};   4'd5: c = {8'd49, 8'd104, 8'd142};
          4'd6: c = {8'd42, 8'd120, 8'd142};  4'd7: c = {8'd35, 8'd136, 8'd142};
          4'd8: c = {8'd31, 8'd152, 8'd139};  4'd9: c = {8'd34, 8'd168, 8'd132};
          4'd10: c = {8'd53, 8'd183, 8'd121}; 4'd11: c = {8'd85, 8'd198, 8'd103};
          4'd12: c = {8'd122, 8'd209, 8'd81}; 4'd13: c = {8'd165, 8'd219, 8'd54};
          4'd14: c = {8'd210, 8'd226, 8'd27}; default: c = {8'd253, 8'd231, 8'd37};
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/linear_stretch_colour_mapper.sv
// Linear stretch colour mapper, top level: registers, controller and datapath.
// Depends on lscm_pkg, lscm_ctrl, lscm_datapath.
//
// Use: items enter on in_valid/in_ready. action 0 (scan) updates the min/max of
// finite samples and gives no result; action 1 (render) gives one pixel on
// out_valid/out_ready (red, green, blue, is_colour).
// A scan passes through decide only; a render passes through decide, setup, 16
// divide steps of the bit-serial divider and map before out_valid rises.
// One item is in flight at a time: in_ready is low until a scan is done or a render's result leaves.
// A stalled receiver holds the pixel in the output register and stops input.
// Reset (rst, synchronous) clears extremes, seen flag and registers:
// limits 0, palette grey, colour allowed 1.
// Config writes (cfg_we, cfg_index, cfg_data) take effect the next cycle; the user
// must make them only while idle (not enforced by the block); unknown indexes are ignored.
module linear_stretch_colour_mapper import lscm_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] sample_value,
  input  logic               sample_finite,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               is_colour
);

  logic signed [31:0] lower_limit, upper_limit;
  logic [1:0]         palette_choice;
  logic               colour_allowed;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit    <= '0;
      upper_limit    <= '0;
      palette_choice <= PAL_GREY;
      colour_allowed <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOWER:   lower_limit    <= cfg_data;
        REG_UPPER:   upper_limit    <= cfg_data;
        REG_PALETTE: palette_choice <= cfg_data[1:0];
        REG_COLOUR:  colour_allowed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lscm_cmd_t  cmd;
  lscm_stat_t stat;

  lscm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  lscm_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_action(action), .in_sample(sample_value), .in_finite(sample_finite),
    .in_start(frame_start),
    .lower_limit, .upper_limit, .palette_choice, .colour_allowed,
    .red, .green, .blue, .is_colour
  );

`ifndef NO_ASSERTIONS
  // never take an item while a pixel is waiting
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // a result held under stall keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(is_colour))
    else $error("pending result changed");
  // grey pixels have equal channels
  a_grey: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_colour |-> red == green && green == blue)
    else $error("grey pixel channels differ");
`endif

endmodule

// File: hw/rtl/lscm_ctrl.sv
// Controller for the linear stretch colour mapper: sequences load, scan, divide and map.
// Depends on lscm_pkg.
module lscm_ctrl import lscm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lscm_stat_t stat,
  output lscm_cmd_t  cmd
);

  typedef enum logic [2:0] {IDLE, DECIDE, SETUP, DIVIDE, FINISH, SHOW} state_t;
  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE:   if (in_valid) state <= DECIDE;
        DECIDE: state <= stat.is_render ? SETUP : IDLE;
        SETUP:  state <= DIVIDE;
        DIVIDE: if (stat.div_done) state <= FINISH;
        FINISH: begin
          state <= SHOW;
          out_valid <= 1'b1;
        end
        SHOW: if (out_ready) begin
          state <= IDLE;
          out_valid <= 1'b0;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.load     = (state == IDLE) && in_valid;
    cmd.scan     = (state == DECIDE) && !stat.is_render;
    cmd.setup    = (state == SETUP);
    cmd.div_step = (state == DIVIDE);
    cmd.finish   = (state == FINISH);
  end

endmodule

// File: hw/rtl/lscm_datapath.sv
// Datapath for the linear stretch colour mapper: extremes, limits, bit-serial
// divider and pixel mapping. Depends on lscm_pkg.
module lscm_datapath import lscm_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  lscm_cmd_t          cmd,
  output lscm_stat_t         stat,
  input  logic               in_action,
  input  logic signed [31:0] in_sample,
  input  logic               in_finite,
  input  logic               in_start,
  input  logic signed [31:0] lower_limit,
  input  logic signed [31:0] upper_limit,
  input  logic [1:0]         palette_choice,
  input  logic               colour_allowed,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               is_colour
);

  localparam int SW = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;

  localparam logic [1:0] SAT_NONE = 2'd0;   // divide
  localparam logic [1:0] SAT_ZERO = 2'd1;   // non-finite, or at or below the lower limit
  localparam logic [1:0] SAT_FULL = 2'd2;   // at or above the upper limit

  logic               act, fin, strt;
  logic signed [31:0] x;
  logic signed [31:0] seen_min, seen_max;
  logic               any_seen;

  logic [33:0]        den;
  logic [50:0]        rem;
  logic [16:0]        quo;
  logic [4:0]         cnt;
  logic [1:0]         sat;

  logic signed [32:0] xs;
  assign xs = 33'(signed'(x));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= in_action;
      fin  <= in_finite;
      strt <= in_start;
      x    <= 32'(signed'(in_sample[SW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_min <= '0;
      seen_max <= '0;
      any_seen <= 1'b0;
    end else if (cmd.scan) begin
      if (fin) begin
        if (strt || !any_seen) begin
          seen_min <= x;
          seen_max <= x;
        end else begin
          if (x < seen_min) seen_min <= x;
          if (x > seen_max) seen_max <= x;
        end
        any_seen <= 1'b1;
      end else if (strt) begin
        any_seen <= 1'b0;
      end
    end
  end

  // limit resolution
  logic signed [32:0] lo_r, hi_r, hi_f;
  always_comb begin
    if (lower_limit != upper_limit) begin
      lo_r = 33'(lower_limit);
      hi_r = 33'(upper_limit);
    end else if (any_seen) begin
      lo_r = 33'(seen_min);
      hi_r = 33'(seen_max);
    end else begin
      lo_r = '0;
      hi_r = 33'(ONE_Q16);
    end
    hi_f = (hi_r <= lo_r) ? (lo_r + 33'(ONE_Q16)) : hi_r;
  end

  // restoring division, one quotient bit a step
  logic [51:0] trial;
  assign trial = {rem, 1'b0} - {18'd0, den};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      den <= 34'(hi_f) - 34'(lo_r);
      rem <= 51'(34'(xs) - 34'(lo_r));
      quo <= '0;
      cnt <= '0;
      if (!fin || xs <= lo_r) sat <= SAT_ZERO;
      else if (xs >= hi_f)    sat <= SAT_FULL;
      else                    sat <= SAT_NONE;
    end else if (cmd.div_step) begin
      cnt <= cnt + 5'd1;
      if (!trial[51]) begin
        rem <= trial[50:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= {rem[49:0], 1'b0};
        quo <= {quo[15:0], 1'b0};
      end
    end
  end

  // (x-lo) < d, so 16 steps give floor((x-lo)*65536/d) below 65536
  assign stat.div_done  = (cnt == 5'd15) && cmd.div_step;
  assign stat.is_render = act;

  logic [16:0] v;
  assign v = (sat == SAT_ZERO) ? 17'd0 : (sat == SAT_FULL) ? 17'd65536 : quo;

  // pixel mapping; weight reaches 1.0 at full scale, so it needs 17 bits
  logic [24:0] gacc, s;
  logic [3:0]  idx;
  logic [16:0] f;
  logic [23:0] ca, cb;
  logic [7:0]  ch [3];
  logic        colour;
  always_comb begin
    gacc = 25'(v) * 25'd255 + 25'd32768;
    s    = 25'(v) * 25'd15;
    idx  = (s[24:16] > 9'd14) ? 4'd14 : s[19:16];
    f    = 17'(s - {5'(idx), 16'd0});
    ca   = ramp_colour(palette_choice, idx);
    cb   = ramp_colour(palette_choice, idx + 4'd1);
    for (int k = 0; k < 3; k++) begin
      logic signed [26:0] acc;
      acc = 27'(signed'({1'b0, ca[8*k +: 8], 16'd0}))
          + 27'(signed'({1'b0, f})) * (27'(signed'({1'b0, cb[8*k +: 8]}))
                                     - 27'(signed'({1'b0, ca[8*k +: 8]})))
          + 27'sd32768;
      ch[k] = acc[23:16];
    end
    colour = (palette_choice != PAL_GREY) && colour_allowed;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      is_colour <= colour;
      if (colour) begin
        red <= ch[2]; green <= ch[1]; blue <= ch[0];
      end else begin
        red <= gacc[23:16]; green <= gacc[23:16]; blue <= gacc[23:16];
      end
    end
  end

endmodule

// File: bench/tb.sv
// Self-checking bench for linear_stretch_colour_mapper: scan and render items
// through valid/ready, pixels checked against an in-bench predictor.
// Depends on lscm_pkg and the mapper RTL.
module tb;
  import lscm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic signed [31:0] sample_value = '0;
  logic sample_finite = 1'b0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red, green, blue;
  logic is_colour;

  linear_stretch_colour_mapper uut (.*);

  always #6 clk = ~clk;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       col;
  } pixel_t;

  // mirror of the block's registers and scan extremes
  logic signed [31:0] lim_lo, lim_hi;
  logic [1:0] pal;
  logic colour_ok;
  logic signed [31:0] ext_min, ext_max;
  logic ext_valid;

  pixel_t pixels_due[$];
  int errors = 0;
  int renders_done = 0;
  int scans_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0d: %s", cycle_count, what);
  endtask

  // anchor channel k (2 red, 1 green, 0 blue) of a ramp, from the ramp tables
  function automatic int anchor(input logic [1:0] p, input int i, input int k);
    int v;
    case (p)
      PAL_ENERGY: case (i)
        0: v = {8'd48, 8'd18, 8'd59};    1: v = {8'd65, 8'd69, 8'd171};
        2: v = {8'd74, 8'd117, 8'd240};  3: v = {8'd70, 8'd160, 8'd253};
        4: v = {8'd49, 8'd198, 8'd223};  5: v = {8'd34, 8'd225, 8'd190};
        6: v = {8'd48, 8'd243, 8'd140};  7: v = {8'd96, 8'd253, 8'd89};
        8: v = {8'd146, 8'd255, 8'd52};  9: v = {8'd188, 8'd243, 8'd42};
        10: v = {8'd222, 8'd220, 8'd49}; 11: v = {8'd247, 8'd187, 8'd49};
        12: v = {8'd254, 8'd145, 8'd38}; 13: v = {8'd241, 8'd99, 8'd22};
        14: v = {8'd216, 8'd60, 8'd9};   default: v = {8'd165, 8'd20, 8'd2};
      endcase
      PAL_JET: case (i)
        0: v = {8'd0, 8'd0, 8'd143};     1: v = {8'd0, 8'd0, 8'd207};
        2: v = {8'd0, 8'd0, 8'd255};     3: v = {8'd0, 8'd63, 8'd255};
        4: v = {8'd0, 8'd127, 8'd255};   5: v = {8'd0, 8'd191, 8'd255};
        6: v = {8'd38, 8'd255, 8'd214};  7: v = {8'd93, 8'd255, 8'd159};
        8: v = {8'd159, 8'd255, 8'd93};  9: v = {8'd214, 8'd255, 8'd38};
        10: v = {8'd255, 8'd208, 8'd0};  11: v = {8'd255, 8'd145, 8'd0};
        12: v = {8'd255, 8'd81, 8'd0};   13: v = {8'd255, 8'd18, 8'd0};
        14: v = {8'd207, 8'd0, 8'd0};    default: v = {8'd143, 8'd0, 8'd0};
      endcase
      default: case (i)
        0: v = {8'd68, 8'd1, 8'd84};     1: v = {8'd72, 8'd26, 8'd108};
        2: v = {8'd71, 8'd47, 8'd125};   3: v = {8'd65, 8'd68, 8'd135};
        4: v = {8'd57, 8'd86, 8'd140};   5: v = {8'd49, 8'd104, 8'd142};
        6: v = {8'd42, 8'd120, 8'd142};  7: v = {8'd35, 8'd136, 8'd142};
        8: v = {8'd31, 8'd152, 8'd139};  9: v = {8'd34, 8'd168, 8'd132};
        10: v = {8'd53, 8'd183, 8'd121}; 11: v = {8'd85, 8'd198, 8'd103};
        12: v = {8'd122, 8'd209, 8'd81}; 13: v = {8'd165, 8'd219, 8'd54};
        14: v = {8'd210, 8'd226, 8'd27}; default: v = {8'd253, 8'd231, 8'd37};
      endcase
    endcase
    return (v >> (8 * k)) & 255;
  endfunction

  // stretch one sample and map it to a pixel; scans only move the extremes
  function automatic void stretch_sample(input logic act, input logic signed [31:0] x,
                                         input logic fin, input logic fs);
    longint lo, hi, v, s, i, f, acc;
    longint ch[3];
    pixel_t px;
    if (!act) begin
      if (fs) ext_valid = 1'b0;
      if (fin) begin
        if (!ext_valid) begin
          ext_min = x; ext_max = x; ext_valid = 1'b1;
        end else begin
          if (x < ext_min) ext_min = x;
          if (x > ext_max) ext_max = x;
        end
      end
      return;
    end
    lo = lim_lo; hi = lim_hi;
    if (lo == hi) begin
      if (ext_valid) begin
        lo = ext_min; hi = ext_max;
      end else begin
        lo = 0; hi = ONE_Q16;
      end
    end
    if (hi <= lo) hi = lo + ONE_Q16;
    v = 0;
    if (fin) begin
      if (x <= lo) v = 0;
      else if (x >= hi) v = ONE_Q16;
      else begin
        v = ((longint'(x) - lo) * ONE_Q16) / (hi - lo);
        if (v > ONE_Q16) v = ONE_Q16;
      end
    end
    if (pal == PAL_GREY || !colour_ok) begin
      acc = (v * 255 + 32768) >>> 16;
      if (acc > 255) acc = 255;
      px = '{r: acc[7:0], g: acc[7:0], b: acc[7:0], col: 1'b0};
    end else begin
      s = v * 15;
      i = s >>> 16;
      if (i > 14) i = 14;
      f = s - (i << 16);
      for (int k = 0; k < 3; k++) begin
        acc = longint'(anchor(pal, i, 2 - k)) * ONE_Q16
              + f * (anchor(pal, i + 1, 2 - k) - anchor(pal, i, 2 - k)) + 32768;
        if (acc < 0) acc = 0;
        acc = acc >>> 16;
        if (acc > 255) acc = 255;
        ch[k] = acc;
      end
      px = '{r: ch[0][7:0], g: ch[1][7:0], b: ch[2][7:0], col: 1'b1};
    end
    pixels_due.push_back(px);
  endfunction

  // output side: random stall, compare on the accepting edge
  always @(posedge clk) begin
    pixel_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        report("pixel with none expected");
      end else begin
        want = pixels_due.pop_front();
        renders_done++;
        if (red !== want.r) report($sformatf("red %0d want %0d", red, want.r));
        if (green !== want.g) report($sformatf("green %0d want %0d", green, want.g));
        if (blue !== want.b) report($sformatf("blue %0d want %0d", blue, want.b));
        if (is_colour !== want.col)
          report($sformatf("is_colour %0b want %0b", is_colour, want.col));
      end
    end
    if (cycle_count > 600000) begin
      $display("timeout with %0d pixels outstanding", pixels_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one item: at least one falling edge, optional gap, hold until taken,
  // predict at acceptance
  task automatic send_item(input logic act, input logic signed [31:0] x,
                           input logic fin, input logic fs);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_valid <= 1'b1;
    action <= act;
    sample_value <= x;
    sample_finite <= fin;
    frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    stretch_sample(act, x, fin, fs);
    if (!act) scans_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // register writes only while idle; scans may still be in flight, so pad
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOWER: lim_lo = d;
      REG_UPPER: lim_hi = d;
      REG_PALETTE: pal = d[1:0];
      default: colour_ok = d[0];
    endcase
  endtask

  // wide range of sample shapes, biased toward the active window
  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh8000_0000 + $urandom_range(3);
      2: return 32'sh7fff_ffff - $urandom_range(3);
      default: return $signed($urandom_range(20 * ONE_Q16)) - 32'sd5 * ONE_Q16;
    endcase
  endfunction

  typedef struct {
    logic act;
    logic signed [31:0] x;
    logic fin;
    logic fs;
    logic chk;       // typed expectation present
    pixel_t px;
  } row_t;

  row_t plan[] = '{
    // after reset: grey, autoscale 0..1 with nothing seen
    '{1'b1, 32'sd0, 1'b1, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{1'b1, 32'sd65536, 1'b1, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{1'b1, 32'sh7fff_ffff, 1'b1, 1'b1, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{1'b1, 32'sh8000_0000, 1'b1, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    // non-finite renders as zero
    '{1'b1, 32'sh7fff_ffff, 1'b0, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{1'b1, 32'sd32768, 1'b1, 1'b0, 1'b0, '0},
    // scan: non-finite first with frame start, then extremes
    '{1'b0, 32'sd999, 1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 32'sh7fff_ffff, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 32'sh8000_0000, 1'b1, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{1'b1, 32'sh7fff_ffff, 1'b1, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{1'b1, 32'sd0, 1'b1, 1'b0, 1'b0, '0},
    // single-valued scan: empty range widened by one
    '{1'b0, 32'sd131072, 1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 32'sd131072, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 32'sd163840, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 32'sd131072, 1'b1, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    // frame start on a non-finite scan clears the seen flag
    '{1'b0, 32'sd5, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 32'sd49152, 1'b1, 1'b0, 1'b0, '0}
  };

  task automatic run_random(input int count);
    logic fs;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        // scan burst: frame start then a few finite/non-finite samples
        for (int j = 0; j < $urandom_range(6, 1); j++)
          send_item(1'b0, pick_sample(), $urandom_range(7) != 0, j == 0);
      end else begin
        fs = 1'($urandom_range(1));
        send_item($urandom_range(15) != 0, pick_sample(), $urandom_range(9) != 0, fs);
      end
    end
  endtask

  initial begin
    int pix_before;
    lim_lo = 0; lim_hi = 0; pal = PAL_GREY; colour_ok = 1'b1;
    ext_min = 0; ext_max = 0; ext_valid = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, grey at reset
    send_idle_pct = 20; recv_idle_pct = 30;
    foreach (plan[r]) begin
      pix_before = pixels_due.size();
      send_item(plan[r].act, plan[r].x, plan[r].fin, plan[r].fs);
      if (plan[r].chk && pixels_due.size() > pix_before) begin
        if (pixels_due[pixels_due.size() - 1] != plan[r].px)
          report($sformatf("row %0d predictor disagrees with table", r));
        pixels_due[pixels_due.size() - 1] = plan[r].px;
      end
    end

    // every palette over a fixed window, including colour forced off
    write_reg(REG_LOWER, 32'hffff_0000);
    write_reg(REG_UPPER, 32'h0001_0000);
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_PALETTE, 32'(p));
      for (int k = 0; k <= 16; k++)
        send_item(1'b1, -32'sd65536 + k * 32'sd8192, 1'b1, 1'b0);
    end
    write_reg(REG_COLOUR, 32'd0);
    send_item(1'b1, 32'sd0, 1'b1, 1'b0);
    write_reg(REG_COLOUR, 32'hffff_fffe);
    send_item(1'b1, 32'sd0, 1'b1, 1'b0);
    write_reg(REG_COLOUR, 32'd1);

    // random phases across settings and idling patterns
    send_idle_pct = 27; recv_idle_pct = 51;
    write_reg(REG_LOWER, 32'h8000_0000);
    write_reg(REG_UPPER, 32'h7fff_ffff);
    write_reg(REG_PALETTE, 32'(PAL_JET));
    run_random(150);

    // sender holds off until everything has drained
    while (pixels_due.size() != 0) @(negedge clk);

    send_idle_pct = 51; recv_idle_pct = 27;
    write_reg(REG_LOWER, 32'd0);
    write_reg(REG_UPPER, 32'd0);
    write_reg(REG_PALETTE, 32'(PAL_VIRIDIS));
    run_random(150);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_LOWER, 32'h0004_0000);
    write_reg(REG_UPPER, 32'hfffe_0000);
    write_reg(REG_PALETTE, 32'(PAL_ENERGY));
    write_reg(REG_COLOUR, 32'd0);
    run_random(100);
    write_reg(REG_COLOUR, 32'd1);
    write_reg(REG_LOWER, $urandom);
    write_reg(REG_UPPER, $urandom);
    run_random(100);

    while (pixels_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Covered %0d pixels and %0d scan samples over four palettes,", renders_done,
             scans_sent);
    $display("fixed, autoscaled and inverted limits, with both sides stalling.");
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
